[design/ngt_pkg.sv]
// package: types, constants and the separator test of the n-gram tokenizer
`timescale 1ns / 1ps

package ngt_pkg;

    localparam int CHAR_BITS     = 21;
    localparam int POSITION_BITS = 24;
    localparam int MAX_GRAM      = 4;
    localparam int N_CELLS       = 4;
    localparam int LEN_BITS      = 3;
    localparam int CNT_BITS      = 3;
    localparam int N_CJK         = 10;

    localparam logic [LEN_BITS-1:0] GRAM_LEN_RESET = 3'd2;

    typedef enum logic [1:0] {
        CFG_GRAM_LENGTH = 2'd0,
        CFG_QUERY_MODE  = 2'd1
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef logic [CHAR_BITS-1:0] t_char;

    localparam t_char CJK_SEP [N_CJK] = '{
        21'h03000, 21'h03001, 21'h03002, 21'h0FF08, 21'h0FF09,
        21'h0FF01, 21'h0FF0C, 21'h0FF1A, 21'h0FF1B, 21'h0FF1F
    };

    function automatic logic is_separator(input t_char c);
        logic hit;
        hit = ((c >= 21'h09) && (c <= 21'h0D)) || (c == 21'h20)
            || ((c >= 21'h21) && (c <= 21'h2F))
            || ((c >= 21'h3A) && (c <= 21'h40))
            || ((c >= 21'h5B) && (c <= 21'h60))
            || ((c >= 21'h7B) && (c <= 21'h7E));
        for (int i = 0; i < N_CJK; i++) begin
            if (c == CJK_SEP[i]) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

[design/ngt_cell.sv]
// one character cell of the window chain
`timescale 1ns / 1ps

module ngt_cell
    import ngt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_char     i_next,
    input  t_char     i_new,
    output t_char     o_char
);

    t_char r_char;
    t_char n_char;

    always_comb begin
        n_char = r_char;
        if (i_ctl.shift) begin
            n_char = i_next;
        end else if (i_ctl.load) begin
            n_char = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

[design/ngt_ctrl.sv]
// sequencer: config, fill count, position counter and result register
`timescale 1ns / 1ps

module ngt_ctrl
    import ngt_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  t_char                          i_char_code,
    input  logic                           i_is_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [POSITION_BITS-1:0]       o_gram_position,
    output logic [LEN_BITS-1:0]            o_gram_len,
    output t_char                          o_gram_char [N_CELLS],
    output logic                           o_last_of_run,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [LEN_BITS-1:0]            i_cfg_data,
    input  t_char                          i_cell_char [N_CELLS],
    output t_cell_ctl                      o_cell_ctl [N_CELLS]
);

    t_state                   r_state, n_state;
    logic [CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [POSITION_BITS-1:0] r_pc, n_pc;
    logic                     r_sep, n_sep;
    logic                     r_last, n_last;
    logic [LEN_BITS-1:0]      r_gl;
    logic                     r_qm;
    logic                     r_ovalid, n_ovalid;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [LEN_BITS-1:0]      r_len, n_len;
    t_char                    r_och [N_CELLS];
    t_char                    n_och [N_CELLS];
    logic                     r_lor, n_lor;

    logic [CNT_BITS-1:0] eff_n;
    logic [CNT_BITS-1:0] cnt_dec;
    logic                in_sep;
    logic                accept;
    logic                flush;
    logic                full_go;
    logic                short_go;
    logic                emit;
    logic                more;
    logic                out_free;
    logic                shift;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign in_sep      = is_separator(i_char_code);
    assign flush       = r_sep || r_last;
    assign cnt_dec     = r_cnt - CNT_BITS'(1);
    assign out_free    = !r_ovalid || i_ready;

    always_comb begin
        if (r_gl == '0) begin
            eff_n = CNT_BITS'(1);
        end else if (r_gl > LEN_BITS'(MAX_GRAM)) begin
            eff_n = CNT_BITS'(MAX_GRAM);
        end else begin
            eff_n = CNT_BITS'(r_gl);
        end
    end

    assign full_go  = !r_sep && (r_cnt >= eff_n);
    assign short_go = flush && !r_qm && (r_cnt != '0);
    assign emit     = full_go || short_go;
    assign more     = (!r_sep && (cnt_dec >= eff_n))
                   || (flush && !r_qm && (cnt_dec != '0));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pc     = r_pc;
        n_sep    = r_sep;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_ready;
        n_pos    = r_pos;
        n_len    = r_len;
        n_och    = r_och;
        n_lor    = r_lor;
        shift    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_sep   = in_sep;
                    n_last  = i_is_last;
                    if (!in_sep) begin
                        n_cnt = r_cnt + CNT_BITS'(1);
                        n_pc  = r_pc + POSITION_BITS'(1);
                    end
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_pos    = r_pc - POSITION_BITS'(r_cnt);
                        n_len    = full_go ? LEN_BITS'(eff_n) : LEN_BITS'(r_cnt);
                        for (int j = 0; j < N_CELLS; j++) begin
                            n_och[j] = (j < int'(n_len)) ? i_cell_char[j] : '0;
                        end
                        n_lor = !more;
                        shift = 1'b1;
                        n_cnt = cnt_dec;
                        if (!more) begin
                            if (flush) n_cnt = '0;
                            if (r_last) n_pc = '0;
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    if (flush) n_cnt = '0;
                    if (r_last) n_pc = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < N_CELLS; i++) begin
            o_cell_ctl[i].shift = shift;
            o_cell_ctl[i].load  = accept && !in_sep && (r_cnt == CNT_BITS'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pc     <= '0;
            r_sep    <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pc     <= n_pc;
            r_sep    <= n_sep;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gl <= GRAM_LEN_RESET;
            r_qm <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_GRAM_LENGTH) r_gl <= i_cfg_data;
            if (i_cfg_index == CFG_QUERY_MODE)  r_qm <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_len <= n_len;
        r_och <= n_och;
        r_lor <= n_lor;
    end

    assign o_valid         = r_ovalid;
    assign o_gram_position = r_pos;
    assign o_gram_len      = r_len;
    assign o_gram_char     = r_och;
    assign o_last_of_run   = r_lor;

endmodule

[design/ngram_tokenizer_core.sv]
// top level of the character n-gram tokenizer
`timescale 1ns / 1ps

// Takes one UTF-32 character per input transaction and emits character n-grams of
// up to gram_length characters (0 acts as 1, above 4 as 4), each with its start
// position among non-separator characters; a separator or is_last flushes pending
// characters as short grams (dropped in query mode), and last_of_run marks the
// final gram of an input. An input is taken in the idle state; in the run state
// the four-cell character chain shifts one place per emitted gram into a single
// result register, and an input yields at most four grams. A stalled output
// holds the run state. The next input is taken as soon as the last gram is loaded.
// Configuration writes are taken in every cycle; index 0 is gram_length,
// index 1 is query_mode, other indexes are ignored.

module ngram_tokenizer_core
    import ngt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CHAR_BITS-1:0]     i_char_code,
    input  logic                     i_is_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [POSITION_BITS-1:0] o_gram_position,
    output logic [LEN_BITS-1:0]      o_gram_len,
    output logic [CHAR_BITS-1:0]     o_gram_char_0,
    output logic [CHAR_BITS-1:0]     o_gram_char_1,
    output logic [CHAR_BITS-1:0]     o_gram_char_2,
    output logic [CHAR_BITS-1:0]     o_gram_char_3,
    output logic                     o_last_of_run,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [LEN_BITS-1:0]      i_cfg_data
);

    t_char     cell_char [N_CELLS];
    t_char     cell_next [N_CELLS];
    t_cell_ctl cell_ctl  [N_CELLS];
    t_char     gram_char [N_CELLS];

    ngt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_gram_position (o_gram_position),
        .o_gram_len      (o_gram_len),
        .o_gram_char     (gram_char),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cell_char     (cell_char),
        .o_cell_ctl      (cell_ctl)
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        if (g == N_CELLS - 1) begin : g_end
            assign cell_next[g] = '0;
        end else begin : g_mid
            assign cell_next[g] = cell_char[g+1];
        end
        ngt_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[g]),
            .i_next (cell_next[g]),
            .i_new  (i_char_code),
            .o_char (cell_char[g])
        );
    end

    assign o_gram_char_0 = gram_char[0];
    assign o_gram_char_1 = gram_char[1];
    assign o_gram_char_2 = gram_char[2];
    assign o_gram_char_3 = gram_char[3];

endmodule

[design/ngt_checker.sv]
// port-level checker of the n-gram tokenizer, bound to the top level
`timescale 1ns / 1ps

module ngt_checker
    import ngt_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [POSITION_BITS-1:0] o_gram_position,
    input logic [LEN_BITS-1:0]      o_gram_len,
    input logic [CHAR_BITS-1:0]     o_gram_char_0,
    input logic [CHAR_BITS-1:0]     o_gram_char_1,
    input logic [CHAR_BITS-1:0]     o_gram_char_2,
    input logic [CHAR_BITS-1:0]     o_gram_char_3,
    input logic                     o_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gram_position)
            && $stable(o_gram_len) && $stable(o_gram_char_0) && $stable(o_last_of_run))
        else $error("stalled result changed");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gram_len >= 3'd1) && (o_gram_len <= 3'd4))
        else $error("gram length out of range");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_gram_len >= 3'd4) || (o_gram_char_3 == '0))
            && ((o_gram_len >= 3'd3) || (o_gram_char_2 == '0))
            && ((o_gram_len >= 3'd2) || (o_gram_char_1 == '0)))
        else $error("unused gram character not zero");

    // one input transaction at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while previous one still at work");

endmodule

bind ngram_tokenizer_core ngt_checker u_ngt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_gram_position (o_gram_position),
    .o_gram_len      (o_gram_len),
    .o_gram_char_0   (o_gram_char_0),
    .o_gram_char_1   (o_gram_char_1),
    .o_gram_char_2   (o_gram_char_2),
    .o_gram_char_3   (o_gram_char_3),
    .o_last_of_run   (o_last_of_run)
);

[tb/ngram_tokenizer_core_test.sv]
// testbench of the n-gram tokenizer: directed and random character streams checked gram by gram
`timescale 1ns / 1ps

module ngram_tokenizer_core_test;
    import ngt_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int STALL_LIMIT    = 1000;
    localparam int N_ASCII_BREAKS = 14;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam t_char ASCII_BREAKS [N_ASCII_BREAKS] = '{
        21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h20, 21'h21,
        21'h2F, 21'h3A, 21'h40, 21'h5B, 21'h60, 21'h7B, 21'h7E
    };

    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef struct packed {
        t_pos                        pos;
        logic [LEN_BITS-1:0]         len;
        t_char [MAX_GRAM-1:0]        chars;
        logic                        run_end;
    } t_gram;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    t_char                    i_char_code = '0;
    logic                     i_is_last   = 1'b0;
    logic                     i_ready     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [1:0]               i_cfg_index = '0;
    logic [LEN_BITS-1:0]      i_cfg_data  = '0;
    logic                     o_ready;
    logic                     o_valid;
    logic                     o_cfg_ready;
    logic [POSITION_BITS-1:0] o_gram_position;
    logic [LEN_BITS-1:0]      o_gram_len;
    t_char                    o_gram_char_0;
    t_char                    o_gram_char_1;
    t_char                    o_gram_char_2;
    t_char                    o_gram_char_3;
    logic                     o_last_of_run;

    t_gram grams_due [$];
    int    err_count      = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    quiet_cycles   = 0;
    int    hold_left      = 0;
    logic  hold_req       = 1'b0;
    logic  hold_ack       = 1'b0;

    // mirror of the tokenizer state and registers
    logic [LEN_BITS-1:0] cfg_gram_len = GRAM_LEN_RESET;
    logic                cfg_query    = 1'b0;
    t_char               win [3]      = '{default: '0};
    int                  win_fill     = 0;
    t_pos                char_count   = '0;

    ngram_tokenizer_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_gram_position (o_gram_position),
        .o_gram_len      (o_gram_len),
        .o_gram_char_0   (o_gram_char_0),
        .o_gram_char_1   (o_gram_char_1),
        .o_gram_char_2   (o_gram_char_2),
        .o_gram_char_3   (o_gram_char_3),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_break_char(input t_char c);
        bit hit;
        hit = ((c >= 21'h09) && (c <= 21'h0D)) || (c == 21'h20)
            || ((c >= 21'h21) && (c <= 21'h2F)) || ((c >= 21'h3A) && (c <= 21'h40))
            || ((c >= 21'h5B) && (c <= 21'h60)) || ((c >= 21'h7B) && (c <= 21'h7E));
        for (int i = 0; i < N_CJK; i++) begin
            if (c == CJK_SEP[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic int eff_gram_len();
        if (cfg_gram_len == 0) return 1;
        if (cfg_gram_len > MAX_GRAM) return MAX_GRAM;
        return int'(cfg_gram_len);
    endfunction

    function automatic void push_gram(input t_char src [5], input int from, input int len,
                                      input t_pos pos);
        t_gram g;
        g.pos     = pos;
        g.len     = LEN_BITS'(len);
        g.chars   = '0;
        g.run_end = 1'b0;
        for (int i = 0; i < len; i++) g.chars[i] = src[from + i];
        grams_due.push_back(g);
    endfunction

    function automatic void predict_grams(input t_char c, input logic at_end);
        t_char held [5];
        int    k;
        int    n;
        int    queued_prior;
        bit    brk;
        brk          = is_break_char(c);
        n            = eff_gram_len();
        queued_prior = grams_due.size();
        held         = '{default: '0};
        k            = win_fill;
        for (int i = 0; i < k; i++) held[i] = win[i];
        if (!brk) begin
            held[k] = c;
            k++;
            char_count++;
            while (k >= n) begin
                push_gram(held, 0, n, char_count - t_pos'(k));
                for (int i = 0; i < 4; i++) held[i] = held[i + 1];
                held[4] = '0;
                k--;
            end
        end
        if (brk || at_end) begin
            if (!cfg_query) begin
                for (int i = 0; i < k; i++)
                    push_gram(held, i, k - i, char_count - t_pos'(k) + t_pos'(i));
            end
            k = 0;
        end
        if (at_end) char_count = '0;
        for (int i = 0; i < 3; i++) win[i] = (i < k) ? held[i] : '0;
        win_fill = k;
        if (grams_due.size() > queued_prior) grams_due[grams_due.size() - 1].run_end = 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_gram want;
        if (i_rst_n && o_valid && i_ready) begin
            if (grams_due.size() == 0) begin
                report_mismatch("unexpected gram position", 32'd0, 32'(o_gram_position));
            end else begin
                want = grams_due.pop_front();
                if (o_gram_position != want.pos)
                    report_mismatch("gram_position", 32'(want.pos), 32'(o_gram_position));
                if (o_gram_len != want.len)
                    report_mismatch("gram_len", 32'(want.len), 32'(o_gram_len));
                if (o_gram_char_0 != want.chars[0])
                    report_mismatch("gram_char_0", 32'(want.chars[0]), 32'(o_gram_char_0));
                if (o_gram_char_1 != want.chars[1])
                    report_mismatch("gram_char_1", 32'(want.chars[1]), 32'(o_gram_char_1));
                if (o_gram_char_2 != want.chars[2])
                    report_mismatch("gram_char_2", 32'(want.chars[2]), 32'(o_gram_char_2));
                if (o_gram_char_3 != want.chars[3])
                    report_mismatch("gram_char_3", 32'(want.chars[3]), 32'(o_gram_char_3));
                if (o_last_of_run != want.run_end)
                    report_mismatch("last_of_run", 32'(want.run_end), 32'(o_last_of_run));
            end
        end
    end

    // result side: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input t_char c, input logic at_end);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_is_last   <= at_end;
        do @(posedge i_clk); while (!o_ready);
        predict_grams(c, at_end);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (grams_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [LEN_BITS-1:0] len_val, input logic qm_val,
                                input bit stray);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_GRAM_LENGTH;
        i_cfg_data  <= len_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_gram_len = len_val;
        i_cfg_index <= CFG_QUERY_MODE;
        i_cfg_data  <= {2'b00, qm_val};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_query = qm_val;
        if (stray) begin
            // writes to unused indexes must leave both registers alone
            i_cfg_index <= CFG_SPARE_LO;
            i_cfg_data  <= LEN_BITS'($urandom);
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_index <= CFG_SPARE_HI;
            i_cfg_data  <= LEN_BITS'($urandom);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_char rand_word_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return t_char'(8'h61 + $urandom_range(25));
        if (pick < 55) return t_char'(8'h30 + $urandom_range(9));
        if (pick < 75) return t_char'(21'h4E00 + $urandom_range(21'h51FF));
        return t_char'($urandom_range(21'h1FFFFF));
    endfunction

    function automatic t_char rand_break_char();
        if ($urandom_range(99) < 70) return ASCII_BREAKS[$urandom_range(N_ASCII_BREAKS - 1)];
        return CJK_SEP[$urandom_range(N_CJK - 1)];
    endfunction

    task automatic test_defaults();
        send_char(21'h61, 1'b0);
        send_char(21'h62, 1'b0);
        send_char(21'h63, 1'b0);
        send_char(21'h20, 1'b0);
        send_char(21'h64, 1'b1);
    endtask

    task automatic test_extreme_codes();
        apply_config(3'd4, 1'b0, 1'b0);
        // full gram plus three short grams on the end of text
        send_char(21'h000000, 1'b0);
        send_char(21'h1FFFFF, 1'b0);
        send_char(21'h10FFFF, 1'b0);
        send_char(21'h110000, 1'b1);
        // separator as the final character only flushes
        send_char(21'h61, 1'b0);
        send_char(21'h62, 1'b0);
        send_char(21'h0FF1F, 1'b1);
    endtask

    task automatic test_query_mode();
        apply_config(3'd3, 1'b1, 1'b0);
        send_char(21'h70, 1'b0);
        send_char(21'h71, 1'b0);
        send_char(21'h03000, 1'b0);
        send_char(21'h72, 1'b0);
        send_char(21'h73, 1'b0);
        send_char(21'h74, 1'b1);
    endtask

    task automatic test_length_limits();
        apply_config(3'd0, 1'b0, 1'b1);
        send_char(21'h61, 1'b0);
        send_char(21'h62, 1'b0);
        apply_config(3'd7, 1'b0, 1'b0);
        send_char(21'h77, 1'b0);
        send_char(21'h78, 1'b0);
        send_char(21'h79, 1'b0);
        // shorter grams while three characters are still held
        apply_config(3'd1, 1'b0, 1'b0);
        send_char(21'h7A, 1'b0);
        apply_config(3'd2, 1'b0, 1'b0);
        send_char(21'h6D, 1'b0);
        send_char(21'h0D, 1'b1);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int sent;
        int word_len;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                word_len = $urandom_range(6, 1);
                for (int i = 0; i < word_len; i++) begin
                    send_char(rand_word_char(), ($urandom_range(99) < 4));
                    sent++;
                end
                send_char(rand_break_char(), ($urandom_range(99) < 15));
                sent++;
            end else begin
                send_char(t_char'($urandom_range(21'h1FFFFF)), ($urandom_range(99) < 10));
                sent++;
            end
        end
    endtask

    task automatic test_random_streams();
        apply_config(3'd4, 1'b0, 1'b1);
        run_random_phase(0, 0, 17);
        apply_config(3'd1, 1'b1, 1'b0);
        run_random_phase(52, 0, 17);
        apply_config(3'd3, 1'b1, 1'b0);
        run_random_phase(0, 52, 17);
        apply_config(3'd2, 1'b0, 1'b0);
        run_random_phase(10, 10, 17);
    endtask

    task automatic test_backpressure();
        apply_config(3'd4, 1'b0, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= ~hold_req;
        for (int i = 0; i < 24; i++) begin
            if (i % 6 == 5) send_char(21'h20, 1'b0);
            else send_char(rand_word_char(), 1'b0);
        end
        // sender waits for every gram before going on
        wait_idle();
        send_char(21'h65, 1'b0);
        send_char(21'h6E, 1'b0);
        send_char(21'h64, 1'b1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_extreme_codes();
        test_query_mode();
        test_length_limits();
        test_random_streams();
        test_backpressure();
        wait_idle();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
design/ngt_pkg.sv
design/ngt_cell.sv
design/ngt_ctrl.sv
design/ngram_tokenizer_core.sv
design/ngt_checker.sv
tb/ngram_tokenizer_core_test.sv
